FILE: rtl/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants of the text sanitize filter
// Character codes, payload structs, the queue entry and the
// character class used by the back end.
// ----------------------------------------------------------------------------
package tsf_pkg;

   // Default depth of the queue between front and back
   localparam int TSF_QUEUE_DEPTH = 4;

   // Character codes
   localparam logic [7:0] TSF_CH_COMMA  = 8'h2C;
   localparam logic [7:0] TSF_CH_TAB    = 8'h09;
   localparam logic [7:0] TSF_CH_NL     = 8'h0A;
   localparam logic [7:0] TSF_CH_CR     = 8'h0D;
   localparam logic [7:0] TSF_CH_BSLASH = 8'h5C;
   localparam logic [7:0] TSF_CH_X      = 8'h58;
   localparam logic [7:0] TSF_CH_LT     = 8'h3C;
   localparam logic [7:0] TSF_CH_GT     = 8'h3E;
   localparam logic [7:0] TSF_CH_SPACE  = 8'h20;
   localparam logic [7:0] TSF_CH_ZERO   = 8'h30;
   localparam logic [7:0] TSF_CH_NINE   = 8'h39;

   // Configuration register indexes
   localparam logic [1:0] TSF_CSR_DELIM = 2'd0;
   localparam logic [1:0] TSF_CSR_TAG   = 2'd1;
   localparam logic [1:0] TSF_CSR_SPACE = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } tsf_in_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_text;
   } tsf_out_type;

   typedef struct packed {
      logic delim_enable;
      logic tag_enable;
      logic space_enable;
   } tsf_cfg_type;

   // One queue entry: up to two characters for the space stage, plus end mark
   typedef struct packed {
      logic [7:0] c0;
      logic [7:0] c1;
      logic [1:0] n;
      logic       last;
   } tsf_cmd_type;

   // Space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic tsf_is_ws(input logic [7:0] c);
      return (c == TSF_CH_SPACE) || ((c >= TSF_CH_TAB) && (c <= TSF_CH_CR));
   endfunction

endpackage

FILE: rtl/text_sanitize_filter_top.sv
// ----------------------------------------------------------------------------
// text_sanitize_filter_top: text sanitize filter
// Delimiter, tag and space stages over a byte stream, with config registers.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle and returns zero to three result
// transfers per byte; the final byte of a text always gives at least one,
// marked by end_of_text. The front end (delimiter and tag stages) accepts a
// byte every cycle while its queue has room; the back end (space stage)
// sends one result per cycle from a registered output while the receiver
// does not stall, so a byte that expands into two or three results holds
// the back end until all are sent and the queue absorbs the difference. An
// accepted byte is written to the queue and its first result then leaves
// through the registered output. Configuration writes are always ready and
// are to be made while the block holds no unfinished text bytes.
module text_sanitize_filter_top
   import tsf_pkg::*;
#(
   parameter int QUEUE_DEPTH = TSF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  tsf_in_type  req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tsf_out_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic        csr_wdata
);

   tsf_cfg_type cfg_ff;
   tsf_cfg_type cfg_in;
   logic        queue_full;
   logic        queue_push;
   logic        queue_pop;
   logic        queue_empty;
   tsf_cmd_type queue_data;
   tsf_cmd_type queue_head;

   assign csr_ready = 1'b1;

   // Decode register writes; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            TSF_CSR_DELIM: cfg_in.delim_enable = csr_wdata;
            TSF_CSR_TAG:   cfg_in.tag_enable   = csr_wdata;
            TSF_CSR_SPACE: cfg_in.space_enable = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (queue_data)
   );

   tsf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .head      (queue_head),
      .empty     (queue_empty)
   );

   tsf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .space_enable (cfg_ff.space_enable),
      .head         (queue_head),
      .empty        (queue_empty),
      .pop          (queue_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

FILE: rtl/tsf_front.sv
// ----------------------------------------------------------------------------
// tsf_front: delimiter and tag stages
// Accepts one byte a cycle while the queue has room, maps delimiters, tracks
// the escape state and queues the surviving characters as one entry.
// ----------------------------------------------------------------------------
module tsf_front
   import tsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tsf_cfg_type cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  tsf_in_type  req_data,
   input  logic        queue_full,
   output logic        queue_push,
   output tsf_cmd_type queue_data
);

   localparam logic [1:0] TAG_NORMAL = 2'd0;
   localparam logic [1:0] TAG_ESC    = 2'd1;
   localparam logic [1:0] TAG_XSEEN  = 2'd2;
   localparam logic [1:0] TAG_ANGLE  = 2'd3;

   logic [1:0]  tag_mode_ff;
   logic [1:0]  tag_mode_in;
   logic [1:0]  mode_next;
   logic [7:0]  ch;
   logic        accept;
   tsf_cmd_type cmd;

   function automatic logic is_drop_tag(input logic [7:0] c);
      case (c)
         8'h42, 8'h62, 8'h49, 8'h69, 8'h55, 8'h75,
         8'h48, 8'h68, 8'h4C, 8'h6C, 8'h43, 8'h63, 8'h78: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // Map delimiters, then run the tag stage on the byte
   always_comb begin
      ch = req_data.in_byte;
      if (cfg.delim_enable &&
          (ch == TSF_CH_COMMA || ch == TSF_CH_TAB || ch == TSF_CH_NL)) begin
         ch = TSF_CH_SPACE;
      end

      cmd.c0   = ch;
      cmd.c1   = ch;
      cmd.n    = 2'd1;
      cmd.last = req_data.in_last;
      mode_next = tag_mode_ff;

      if (cfg.tag_enable) begin
         case (tag_mode_ff)
            TAG_ESC: begin
               mode_next = TAG_NORMAL;
               if (is_drop_tag(ch)) begin
                  cmd.n = 2'd0;
               end else if (ch == TSF_CH_X) begin
                  cmd.n     = 2'd0;
                  mode_next = TAG_XSEEN;
               end else begin
                  cmd.c0 = TSF_CH_BSLASH;
                  cmd.n  = 2'd2;
               end
            end
            TAG_XSEEN: begin
               mode_next = TAG_NORMAL;
               if (ch >= TSF_CH_ZERO && ch <= TSF_CH_NINE) begin
                  cmd.n = 2'd0;
               end else if (ch == TSF_CH_LT) begin
                  cmd.n     = 2'd0;
                  mode_next = TAG_ANGLE;
               end else if (ch == TSF_CH_BSLASH) begin
                  cmd.c0    = TSF_CH_X;
                  cmd.n     = 2'd1;
                  mode_next = TAG_ESC;
               end else begin
                  cmd.c0 = TSF_CH_X;
                  cmd.n  = 2'd2;
               end
            end
            TAG_ANGLE: begin
               cmd.n = 2'd0;
               if (ch == TSF_CH_GT) begin
                  mode_next = TAG_NORMAL;
               end
            end
            default: begin
               if (ch == TSF_CH_BSLASH) begin
                  cmd.n     = 2'd0;
                  mode_next = TAG_ESC;
               end
            end
         endcase
         // Release a held X at end of text
         if (req_data.in_last && mode_next == TAG_XSEEN) begin
            cmd.c0 = TSF_CH_X;
            cmd.n  = 2'd1;
         end
      end
   end

   // Advance the tag state; end of text returns it to normal
   always_comb begin
      tag_mode_in = tag_mode_ff;
      if (accept) begin
         tag_mode_in = req_data.in_last ? TAG_NORMAL : mode_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_mode_ff <= TAG_NORMAL;
      end else begin
         tag_mode_ff <= tag_mode_in;
      end
   end

   // Drop entries that carry nothing
   assign queue_push = accept && (cmd.n != 2'd0 || cmd.last);
   assign queue_data = cmd;

endmodule

FILE: rtl/tsf_queue.sv
// ----------------------------------------------------------------------------
// tsf_queue: command queue between front and back
// Small register FIFO; the head entry is read directly.
// ----------------------------------------------------------------------------
module tsf_queue
   import tsf_pkg::*;
#(
   parameter int DEPTH = TSF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  tsf_cmd_type push_data,
   output logic        full,
   input  logic        pop,
   output tsf_cmd_type head,
   output logic        empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tsf_cmd_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue pushed while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");
`endif

endmodule

FILE: rtl/tsf_back.sv
// ----------------------------------------------------------------------------
// tsf_back: space stage and result serializer
// Runs the whitespace trim and collapse on the queue head and sends
// its results one transfer a cycle, unless stalled, via a registered output.
// ----------------------------------------------------------------------------
module tsf_back
   import tsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        space_enable,
   input  tsf_cmd_type head,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tsf_out_type rsp_data
);

   logic        started_ff;
   logic        started_in;
   logic        pend_valid_ff;
   logic        pend_valid_in;
   logic [7:0]  pend_char_ff;
   logic [7:0]  pend_char_in;
   logic [1:0]  idx_ff;
   logic [1:0]  idx_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   tsf_out_type rsp_data_ff;
   tsf_out_type rsp_data_in;

   logic        st;
   logic        pv;
   logic [7:0]  pc;
   logic [7:0]  e [4];
   logic [1:0]  cnt;
   logic [1:0]  nitems;
   logic        out_free;
   logic        load;

   // Run the space stage over the head entry
   always_comb begin
      logic [7:0] c;
      st  = started_ff;
      pv  = pend_valid_ff;
      pc  = pend_char_ff;
      cnt = 2'd0;
      for (int k = 0; k < 4; k++) begin
         e[k] = 8'h00;
      end
      for (int k = 0; k < 2; k++) begin
         c = (k == 0) ? head.c0 : head.c1;
         if (2'(k) < head.n) begin
            if (!space_enable) begin
               if (pv) begin
                  e[cnt] = pc;
                  cnt    = cnt + 2'd1;
                  pv     = 1'b0;
               end
               e[cnt] = c;
               cnt    = cnt + 2'd1;
            end else if (tsf_is_ws(c)) begin
               if (st) begin
                  pv = 1'b1;
                  pc = c;
               end
            end else begin
               if (pv) begin
                  e[cnt] = pc;
                  cnt    = cnt + 2'd1;
                  pv     = 1'b0;
               end
               st     = 1'b1;
               e[cnt] = c;
               cnt    = cnt + 2'd1;
            end
         end
      end
      // Keep a trailing run only when it ends in a non-space
      if (head.last && pv && pc != TSF_CH_SPACE) begin
         e[cnt] = pc;
         cnt    = cnt + 2'd1;
      end
      nitems = (head.last && cnt == 2'd0) ? 2'd1 : cnt;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = !empty && nitems != 2'd0 && out_free;
   assign pop      = !empty && (nitems == 2'd0 ||
                                (load && 2'(idx_ff + 2'd1) == nitems));

   // Build the next result transfer
   always_comb begin
      rsp_data_in.out_byte    = e[idx_ff];
      rsp_data_in.byte_valid  = (cnt != 2'd0);
      rsp_data_in.end_of_text = head.last && (2'(idx_ff + 2'd1) == nitems);
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Commit stage state when the entry retires; end of text resets it
   always_comb begin
      started_in    = started_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      idx_in        = idx_ff;
      if (pop) begin
         idx_in = 2'd0;
         if (head.last) begin
            started_in    = 1'b0;
            pend_valid_in = 1'b0;
            pend_char_in  = 8'h00;
         end else begin
            started_in    = st;
            pend_valid_in = pv;
            pend_char_in  = pc;
         end
      end else if (load) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_char_ff  <= 8'h00;
         idx_ff        <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         started_ff    <= started_in;
         pend_valid_ff <= pend_valid_in;
         pend_char_ff  <= pend_char_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold the payload while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/sv/tb_text_sanitize_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_sanitize_filter_top: self-checking bench for the text sanitize filter
// Walks a short table of directed texts and then random texts of plain text,
// blanks, good and broken tags and random bytes, under several register settings
// and sender/receiver idle patterns. Every result transfer is checked field by
// field against a typed-in result or a model of the delimiter, tag and space stages.
// ----------------------------------------------------------------------------
module tb_text_sanitize_filter_top;
   import tsf_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int NUM_PHASES    = 16;
   localparam int PHASE_ITEMS   = 13;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [7:0] CH_VT      = 8'h0B;
   localparam logic [7:0] CH_FF      = 8'h0C;

   // Register settings, bit order {delim, tag, space}
   localparam logic [2:0] CFG_OFF   = 3'b000;
   localparam logic [2:0] CFG_SPACE = 3'b001;
   localparam logic [2:0] CFG_TAG   = 3'b010;
   localparam logic [2:0] CFG_ALL   = 3'b111;

   typedef enum logic [1:0] {TAG_PLAIN, TAG_ESCAPE, TAG_XSEEN, TAG_ANGLE} tag_state_type;

   typedef struct packed {
      logic [2:0]  cfg;
      tsf_in_type  item;
      logic        has_ref;
      tsf_out_type ref_out;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   tsf_in_type  req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   tsf_out_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic        csr_wdata = 1'b0;

   // Typed-in result that travels alongside the current input transfer
   logic        req_has_ref = 1'b0;
   tsf_out_type req_ref = '0;

   // Model state and registers
   logic          cfg_delim = 1'b0;
   logic          cfg_tag = 1'b0;
   logic          cfg_space = 1'b0;
   tag_state_type tag_state = TAG_PLAIN;
   logic          text_started = 1'b0;
   logic          held_valid = 1'b0;
   logic [7:0]    held_char = '0;
   logic [7:0]    step_chars [$];
   tsf_out_type   cleaned_fifo [$];

   int          error_count = 0;
   int          result_count = 0;
   int          gap_pct = 0;
   int          stall_pct = 0;
   logic [2:0]  live_cfg = CFG_OFF;
   dir_row_type dir_rows [$];
   logic [7:0]  text_bytes [$];
   int          phase;
   int          sent;
   int          i;
   tsf_out_type want;

   logic [7:0]  blank_set [7] = '{TSF_CH_SPACE, TSF_CH_TAB, TSF_CH_NL, CH_VT, CH_FF,
                                  TSF_CH_CR, TSF_CH_COMMA};
   string       tag_letters = "BbIiUuHhLlCcx";

   text_sanitize_filter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Model of the three stages
   // ------------------------------------------------------------------------
   function automatic logic is_blank(input logic [7:0] c);
      return (c == TSF_CH_SPACE) || (c >= TSF_CH_TAB && c <= TSF_CH_CR);
   endfunction

   function automatic logic is_format_letter(input logic [7:0] c);
      case (c)
         "B", "b", "I", "i", "U", "u", "H", "h", "L", "l", "C", "c", "x": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic put_char(input logic [7:0] c);
      if (step_chars.size() < 3) step_chars.push_back(c);
   endtask

   task automatic space_filter(input logic [7:0] c);
      if (!cfg_space || !is_blank(c)) begin
         // release any held blank ahead of this character
         if (held_valid) begin
            put_char(held_char);
            held_valid = 1'b0;
         end
         if (cfg_space) text_started = 1'b1;
         put_char(c);
      end else if (text_started) begin
         // hold the latest blank of the run
         held_valid = 1'b1;
         held_char  = c;
      end
   endtask

   task automatic plain_char(input logic [7:0] c);
      if (c == TSF_CH_BSLASH) tag_state = TAG_ESCAPE;
      else space_filter(c);
   endtask

   task automatic tag_filter(input logic [7:0] c);
      if (!cfg_tag) begin
         space_filter(c);
      end else begin
         case (tag_state)
            TAG_ESCAPE: begin
               tag_state = TAG_PLAIN;
               if (c == TSF_CH_X) begin
                  tag_state = TAG_XSEEN;
               end else if (!is_format_letter(c)) begin
                  space_filter(TSF_CH_BSLASH);
                  space_filter(c);
               end
            end
            TAG_XSEEN: begin
               tag_state = TAG_PLAIN;
               if (c == TSF_CH_LT) begin
                  tag_state = TAG_ANGLE;
               end else if (c < TSF_CH_ZERO || c > TSF_CH_NINE) begin
                  // not a tag after all: keep the X, reprocess the byte
                  space_filter(TSF_CH_X);
                  plain_char(c);
               end
            end
            TAG_ANGLE: begin
               if (c == TSF_CH_GT) tag_state = TAG_PLAIN;
            end
            default: plain_char(c);
         endcase
      end
   endtask

   task automatic sanitize_byte(input tsf_in_type d);
      logic [7:0] c;
      c = d.in_byte;
      step_chars.delete();
      if (cfg_delim && (c == TSF_CH_COMMA || c == TSF_CH_TAB || c == TSF_CH_NL))
         c = TSF_CH_SPACE;
      tag_filter(c);
      if (d.in_last) begin
         // flush a dangling backslash-X, then a held non-space blank
         if (cfg_tag && tag_state == TAG_XSEEN) space_filter(TSF_CH_X);
         if (held_valid && held_char != TSF_CH_SPACE) put_char(held_char);
         tag_state    = TAG_PLAIN;
         text_started = 1'b0;
         held_valid   = 1'b0;
         held_char    = '0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checking, model update on every accepted transfer
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int exp_val);
      $display("ERROR: %0t result %0d %s: got %0h, expected %0h",
               $realtime, result_count, what, got, exp_val);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_delim    = 1'b0;
         cfg_tag      = 1'b0;
         cfg_space    = 1'b0;
         tag_state    = TAG_PLAIN;
         text_started = 1'b0;
         held_valid   = 1'b0;
         held_char    = '0;
         cleaned_fifo.delete();
      end else begin
         // check the result transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (cleaned_fifo.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_data, 0);
            end else begin
               want = cleaned_fifo.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
               if (rsp_data.byte_valid !== want.byte_valid)
                  report_mismatch("byte_valid", rsp_data.byte_valid, want.byte_valid);
               if (rsp_data.end_of_text !== want.end_of_text)
                  report_mismatch("end_of_text", rsp_data.end_of_text, want.end_of_text);
            end
            result_count++;
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               TSF_CSR_DELIM: cfg_delim = csr_wdata;
               TSF_CSR_TAG:   cfg_tag   = csr_wdata;
               TSF_CSR_SPACE: cfg_space = csr_wdata;
               default: begin end
            endcase
         end
         // predict the results of an accepted byte
         if (req_valid && !req_stall) begin
            sanitize_byte(req_data);
            if (req_has_ref) begin
               cleaned_fifo.push_back(req_ref);
            end else begin
               foreach (step_chars[k])
                  cleaned_fifo.push_back(tsf_out_type'{step_chars[k], 1'b1,
                     req_data.in_last && (k == step_chars.size() - 1)});
               if (req_data.in_last && step_chars.size() == 0)
                  cleaned_fifo.push_back(tsf_out_type'{8'h00, 1'b0, 1'b1});
            end
         end
      end
   end

   // Receiver stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic send_item(input tsf_in_type d, input logic has_ref, input tsf_out_type r);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_data    <= d;
      req_has_ref <= has_ref;
      req_ref     <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Hold the sender until every predicted result is out, then let the pipe settle
   task automatic drain_block();
      req_valid <= 1'b0;
      // let the checker record the last accepted transfer first
      @(posedge clock);
      while (cleaned_fifo.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input logic [2:0] cfg, input logic poke_unused);
      if (poke_unused) write_csr(CSR_UNUSED, 1'b1);
      write_csr(TSF_CSR_DELIM, cfg[2]);
      write_csr(TSF_CSR_TAG, cfg[1]);
      write_csr(TSF_CSR_SPACE, cfg[0]);
      csr_valid <= 1'b0;
      live_cfg = cfg;
   endtask

   task automatic add_row(input logic [2:0] cfg, input logic [7:0] c, input logic last,
                          input logic has_ref, input tsf_out_type r);
      dir_rows.push_back(dir_row_type'{cfg, tsf_in_type'{c, last}, has_ref, r});
   endtask

   task automatic add_escape_x();
      text_bytes.push_back(TSF_CH_BSLASH);
      text_bytes.push_back(TSF_CH_X);
   endtask

   // Append one token: mostly well-formed tags and text, some noise and broken tags
   task automatic add_token();
      int         pick;
      int         n;
      logic [7:0] b;
      pick = $urandom_range(19);
      case (pick)
         0, 1, 2, 3: text_bytes.push_back(8'($urandom_range(8'h7A, 8'h61)));  // lowercase
         4, 5, 6: begin
            n = $urandom_range(3, 1);
            repeat (n) text_bytes.push_back(blank_set[$urandom_range(6)]);
         end
         7, 8: begin
            text_bytes.push_back(TSF_CH_BSLASH);
            text_bytes.push_back(tag_letters[$urandom_range(12)]);
         end
         9: begin
            add_escape_x();
            text_bytes.push_back(8'($urandom_range(TSF_CH_NINE, TSF_CH_ZERO)));
         end
         10, 11: begin
            add_escape_x();
            text_bytes.push_back(TSF_CH_LT);
            n = $urandom_range(3);
            repeat (n) begin
               do b = 8'($urandom_range(255, 1)); while (b == TSF_CH_GT);
               text_bytes.push_back(b);
            end
            text_bytes.push_back(TSF_CH_GT);
         end
         12: begin
            add_escape_x();
            text_bytes.push_back(8'($urandom_range(255, 1)));
         end
         13: begin
            text_bytes.push_back(TSF_CH_BSLASH);
            text_bytes.push_back(8'($urandom_range(255, 1)));
         end
         14: begin
            text_bytes.push_back(TSF_CH_BSLASH);
            text_bytes.push_back(TSF_CH_BSLASH);
         end
         15, 16: text_bytes.push_back(8'($urandom_range(255, 1)));
         17: text_bytes.push_back(TSF_CH_BSLASH);
         18: add_escape_x();
         default: begin
            // angle run left open
            add_escape_x();
            text_bytes.push_back(TSF_CH_LT);
         end
      endcase
   endtask

   initial begin
      // directed texts: plain extremes, tags, trimming, end-of-text cases
      add_row(CFG_OFF, 8'h01, 1'b0, 1'b1, tsf_out_type'{8'h01, 1'b1, 1'b0});
      add_row(CFG_OFF, 8'hFF, 1'b1, 1'b1, tsf_out_type'{8'hFF, 1'b1, 1'b1});
      // lone backslash at end
      add_row(CFG_TAG, TSF_CH_BSLASH, 1'b1, 1'b1, tsf_out_type'{8'h00, 1'b0, 1'b1});
      // drop tag, X digit, X other, double backslash, unclosed angle run
      add_row(CFG_TAG, TSF_CH_BSLASH, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, "b", 1'b0, 1'b0, '0);
      add_row(CFG_TAG, TSF_CH_BSLASH, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, TSF_CH_X, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, "9", 1'b0, 1'b0, '0);
      add_row(CFG_TAG, TSF_CH_BSLASH, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, TSF_CH_X, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, "Z", 1'b0, 1'b0, '0);
      add_row(CFG_TAG, TSF_CH_BSLASH, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, TSF_CH_BSLASH, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, TSF_CH_BSLASH, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, TSF_CH_X, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, TSF_CH_LT, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, "q", 1'b1, 1'b1, tsf_out_type'{8'h00, 1'b0, 1'b1});
      // backslash-X at end keeps the X
      add_row(CFG_TAG, TSF_CH_BSLASH, 1'b0, 1'b0, '0);
      add_row(CFG_TAG, TSF_CH_X, 1'b1, 1'b1, tsf_out_type'{TSF_CH_X, 1'b1, 1'b1});
      // leading trim, collapsed run, trailing vertical tab kept
      add_row(CFG_ALL, TSF_CH_SPACE, 1'b0, 1'b0, '0);
      add_row(CFG_ALL, TSF_CH_COMMA, 1'b0, 1'b0, '0);
      add_row(CFG_ALL, "a", 1'b0, 1'b0, '0);
      add_row(CFG_ALL, TSF_CH_TAB, 1'b0, 1'b0, '0);
      add_row(CFG_ALL, TSF_CH_SPACE, 1'b0, 1'b0, '0);
      add_row(CFG_ALL, "b", 1'b0, 1'b0, '0);
      add_row(CFG_ALL, CH_VT, 1'b1, 1'b1, tsf_out_type'{CH_VT, 1'b1, 1'b1});
      // whitespace-only text
      add_row(CFG_SPACE, TSF_CH_SPACE, 1'b1, 1'b1, tsf_out_type'{8'h00, 1'b0, 1'b1});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table; registers change only between texts
      for (i = 0; i < dir_rows.size(); i++) begin
         if (i == 0 || (dir_rows[i-1].item.in_last && dir_rows[i].cfg != live_cfg)) begin
            drain_block();
            set_config(dir_rows[i].cfg, 1'b0);
         end
         send_item(dir_rows[i].item, dir_rows[i].has_ref, dir_rows[i].ref_out);
      end

      // random texts over all settings and idle patterns
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_block();
         case (phase / 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 70; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 70; end
            default: begin gap_pct = 33; stall_pct = 33; end
         endcase
         set_config(3'((phase * 5) % 8), phase == 0);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            text_bytes.delete();
            repeat ($urandom_range(6, 1)) add_token();
            for (int k = 0; k < text_bytes.size(); k++) begin
               if ((phase == 1 && sent == 5) || $urandom_range(39) == 0) drain_block();
               send_item(tsf_in_type'{text_bytes[k], k == text_bytes.size() - 1}, 1'b0, '0);
               sent++;
            end
         end
      end

      drain_block();
      if (cleaned_fifo.size() != 0) report_mismatch("missing results", 0, cleaned_fifo.size());
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Run limit
   initial begin
      #(2_000_000);
      $display("ERROR: run limit reached with %0d results outstanding", cleaned_fifo.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
